### hw/rtl/point_distance_2d_macros.svh
// Assertion macros for the point distance RTL; pdist_skid uses them.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef POINT_DISTANCE_2D_MACROS_SVH
`define POINT_DISTANCE_2D_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define PD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define PD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pdist_pkg.sv
// Types shared by the point distance pipeline modules.
// No dependencies.
package pdist_pkg;

  // Control that travels beside the payload through every pipeline stage.
  typedef struct packed {
    logic valid;
    logic last;
  } pdist_tag_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_QUERY_X = 1'b0,
    CFG_QUERY_Y = 1'b1
  } pdist_cfg_e;

endpackage

### hw/rtl/pdist_sq.sv
// Front end of the distance pipeline: absolute differences, squares and their sum.
// Three register stages. Depends on pdist_pkg.
module pdist_sq #(
  parameter int unsigned CW = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  pdist_pkg::pdist_tag_t  tag_i,
  input  logic [CW-1:0]          x_i,
  input  logic [CW-1:0]          y_i,
  input  logic [CW-1:0]          qx_i,
  input  logic [CW-1:0]          qy_i,
  output pdist_pkg::pdist_tag_t  tag_o,
  output logic [2*CW:0]          sum_o
);
  import pdist_pkg::*;

  logic [CW:0]     dx_s, dy_s, dx_neg, dy_neg;
  logic [CW-1:0]   dx_abs, dy_abs;
  logic [CW-1:0]   dx_q, dy_q;
  logic [2*CW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic [2*CW:0]   sum_d, sum_q;
  pdist_tag_t      tag1_q, tag2_q, tag3_q;

  // Sign-extended differences are exact; their magnitude always fits CW bits.
  assign dx_s   = {x_i[CW-1], x_i} - {qx_i[CW-1], qx_i};
  assign dy_s   = {y_i[CW-1], y_i} - {qy_i[CW-1], qy_i};
  assign dx_neg = ~dx_s + {{CW{1'b0}}, 1'b1};
  assign dy_neg = ~dy_s + {{CW{1'b0}}, 1'b1};
  assign dx_abs = dx_s[CW] ? dx_neg[CW-1:0] : dx_s[CW-1:0];
  assign dy_abs = dy_s[CW] ? dy_neg[CW-1:0] : dy_s[CW-1:0];

  assign sqx_d = {{CW{1'b0}}, dx_q} * {{CW{1'b0}}, dx_q};
  assign sqy_d = {{CW{1'b0}}, dy_q} * {{CW{1'b0}}, dy_q};
  assign sum_d = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= dx_abs;
      dy_q  <= dy_abs;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sum_q <= sum_d;
    end
  end

  assign tag_o = tag3_q;
  assign sum_o = sum_q;

endmodule

### hw/rtl/pdist_sqrt_step.sv
// One stage of the restoring square root: settles one result bit per stage.
// Depends on pdist_pkg.
module pdist_sqrt_step #(
  parameter int unsigned RW   = 25,
  parameter int unsigned STEP = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  pdist_pkg::pdist_tag_t  tag_i,
  input  logic [2*RW-1:0]        rem_i,
  input  logic [2*RW-1:0]        res_i,
  input  logic                   last_i,
  output pdist_pkg::pdist_tag_t  tag_o,
  output logic [2*RW-1:0]        rem_o,
  output logic [2*RW-1:0]        res_o
);
  import pdist_pkg::*;

  localparam int unsigned NW = 2 * RW;
  // Weight of the trial bit, a power of four that falls by a factor of four each stage.
  localparam logic [NW-1:0] TBIT = {{(NW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - STEP));

  logic [NW:0]   trial;
  logic          fits;
  logic [NW-1:0] rem_d, res_d, rem_q, res_q;
  pdist_tag_t    tag_d, tag_q;

  assign trial = {1'b0, res_i} + {1'b0, TBIT};
  assign fits  = {1'b0, rem_i} >= trial;

  always_comb begin
    tag_d      = tag_i;
    tag_d.last = last_i;
    if (fits) begin
      rem_d = rem_i - trial[NW-1:0];
      res_d = (res_i >> 1) + TBIT;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign tag_o = tag_q;
  assign rem_o = rem_q;
  assign res_o = res_q;

endmodule

### hw/rtl/pdist_skid.sv
// Output register with a skid entry, so the input side sees a registered ready.
// Depends on pdist_pkg and the assertion macros.
`include "point_distance_2d_macros.svh"

module pdist_skid #(
  parameter int unsigned W = 27
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [W-1:0] in_data_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output logic [W-1:0] out_data_o,
  input  logic         out_ready_i
);
  import pdist_pkg::*;

  logic         o_valid_q, o_valid_d;
  logic         sk_valid_q, sk_valid_d;
  logic [W-1:0] o_data_q, o_data_d;
  logic [W-1:0] sk_data_q, sk_data_d;
  logic         in_fire;

  assign in_ready_o = !sk_valid_q;
  assign in_fire    = in_valid_i && !sk_valid_q;

  always_comb begin
    o_valid_d  = o_valid_q;
    o_data_d   = o_data_q;
    sk_valid_d = sk_valid_q;
    sk_data_d  = sk_data_q;
    if (out_ready_i || !o_valid_q) begin
      if (sk_valid_q) begin
        o_valid_d  = 1'b1;
        o_data_d   = sk_data_q;
        sk_valid_d = 1'b0;
      end else begin
        o_valid_d = in_fire;
        o_data_d  = in_data_i;
      end
    end else if (in_fire) begin
      // The output is held, so the arriving transfer parks in the skid entry.
      sk_valid_d = 1'b1;
      sk_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else begin
      o_valid_q  <= o_valid_d;
      sk_valid_q <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_data_q  <= o_data_d;
    sk_data_q <= sk_data_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

  `PD_ASSERT(a_skid_implies_out, !sk_valid_q || o_valid_q, "skid entry full with empty output")
  `PD_ASSERT_NEXT(a_park, o_valid_q && !out_ready_i && in_fire, sk_valid_q, "held transfer lost")
  `PD_ASSERT_NEXT(a_drain, sk_valid_q && out_ready_i, !sk_valid_q && o_valid_q, "skid not drained")

endmodule

### hw/rtl/point_distance_2d.sv
// Point distance to a configured query point: top level with the configuration registers.
// Depends on pdist_pkg, pdist_sq, pdist_sqrt_step and pdist_skid.
//
// Each transfer on the slave stream carries one point and yields exactly one distance
// on the master stream, in order, with tlast copied through. The block takes one point
// every clock cycle while the master side accepts distances. A point passes through the
// registered differences, squares and sum, then the COORD_WIDTH + 1 stage square root
// chain with one result bit per stage, and last the output register. A stalled master
// side halts the whole pipeline; the skid entry at the output keeps s_axis_tready a
// registered signal. Write the query registers only while no point is in flight.
module point_distance_2d #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [COORD_WIDTH-1:0] cfg_wdata_i,
  // Point stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata fields from bit 0: point_x, point_y, zero padding.
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                   s_axis_tlast,
  // Distance stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata fields from bit 0: distance, zero padding.
  output logic [((COORD_WIDTH+9)/8)*8-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);
  import pdist_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned RW     = CW + 1;
  localparam int unsigned NW     = 2 * RW;
  localparam int unsigned DW     = CW + 2;
  localparam int unsigned OUT_TW = ((CW + 9) / 8) * 8;

  logic [CW-1:0] qx_q, qy_q;
  logic          en;
  pdist_tag_t    in_tag, sq_tag;
  logic [2*CW:0] sum;
  pdist_tag_t    tag_w [RW+1];
  logic [NW-1:0] rem_w [RW+1];
  logic [NW-1:0] res_w [RW+1];
  logic [DW:0]   skid_in, skid_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pdist_cfg_e'(cfg_index_i))
        CFG_QUERY_X: qx_q <= cfg_wdata_i;
        CFG_QUERY_Y: qy_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_tag.valid = s_axis_tvalid;
  assign in_tag.last  = s_axis_tlast;

  pdist_sq #(.CW(CW)) u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (in_tag),
    .x_i    (s_axis_tdata[CW-1:0]),
    .y_i    (s_axis_tdata[2*CW-1:CW]),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .tag_o  (sq_tag),
    .sum_o  (sum)
  );

  assign tag_w[0] = sq_tag;
  assign rem_w[0] = NW'(sum);
  assign res_w[0] = '0;

  for (genvar g = 0; g < RW; g++) begin : g_root
    pdist_sqrt_step #(.RW(RW), .STEP(g)) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tag_i  (tag_w[g]),
      .rem_i  (rem_w[g]),
      .res_i  (res_w[g]),
      .last_i (tag_w[g].last),
      .tag_o  (tag_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .res_o  (res_w[g+1])
    );
  end

  assign skid_in = {tag_w[RW].last, res_w[RW][DW-1:0]};

  pdist_skid #(.W(DW + 1)) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tag_w[RW].valid),
    .in_data_i   (skid_in),
    .in_ready_o  (en),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (skid_out),
    .out_ready_i (m_axis_tready)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = OUT_TW'(skid_out[DW-1:0]);
  assign m_axis_tlast  = skid_out[DW];

endmodule
